FILE: sv/vtc_pkg.sv
`default_nettype none
package vtc_pkg;

   localparam int unsigned PcWidth = 6;

   localparam logic [7:0] CSI_BYTE   = 8'h9b;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] POS_BIAS   = 8'd31;

   typedef enum logic [2:0] {
      SRC_LIT,
      SRC_ARG,
      SRC_ROW_T,
      SRC_ROW_O,
      SRC_COL_T,
      SRC_COL_O
   } src_type;

   typedef struct packed {
      src_type    src;
      logic [7:0] lit;
      logic       last;
   } ctrl_word_type;

   typedef struct packed {
      logic               go;
      logic [PcWidth-1:0] pc;
      logic [7:0]         arg;
   } seq_start_type;

   localparam logic [PcWidth-1:0] A_CSI_ARG = 6'd0;
   localparam logic [PcWidth-1:0] A_ARG     = 6'd2;
   localparam logic [PcWidth-1:0] A_LINE    = 6'd3;
   localparam logic [PcWidth-1:0] A_CUR_ON  = 6'd6;
   localparam logic [PcWidth-1:0] A_CUR_OFF = 6'd9;
   localparam logic [PcWidth-1:0] A_DEL_INS = 6'd13;
   localparam logic [PcWidth-1:0] A_VIDEO   = 6'd17;
   localparam logic [PcWidth-1:0] A_CURSOR  = 6'd26;

   function automatic ctrl_word_type cw(src_type src, logic [7:0] lit, logic last);
      ctrl_word_type w;
      w.src  = src;
      w.lit  = lit;
      w.last = last;
      return w;
   endfunction

   function automatic ctrl_word_type microcode(logic [PcWidth-1:0] pc);
      ctrl_word_type w;
      case (pc)
         6'd0:  w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd1:  w = cw(SRC_ARG, 8'h00, 1'b1);
         6'd2:  w = cw(SRC_ARG, 8'h00, 1'b1);
         6'd3:  w = cw(SRC_LIT, 8'h0a, 1'b0);
         6'd4:  w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd5:  w = cw(SRC_LIT, 8'h4c, 1'b1);
         6'd6:  w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd7:  w = cw(SRC_LIT, 8'h20, 1'b0);
         6'd8:  w = cw(SRC_LIT, 8'h70, 1'b1);
         6'd9:  w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd10: w = cw(SRC_LIT, 8'h30, 1'b0);
         6'd11: w = cw(SRC_LIT, 8'h20, 1'b0);
         6'd12: w = cw(SRC_LIT, 8'h70, 1'b1);
         6'd13: w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd14: w = cw(SRC_LIT, 8'h4d, 1'b0);
         6'd15: w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd16: w = cw(SRC_LIT, 8'h4c, 1'b1);
         6'd17: w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd18: w = cw(SRC_ARG, 8'h00, 1'b0);
         6'd19: w = cw(SRC_LIT, 8'h3b, 1'b0);
         6'd20: w = cw(SRC_LIT, 8'h33, 1'b0);
         6'd21: w = cw(SRC_LIT, 8'h31, 1'b0);
         6'd22: w = cw(SRC_LIT, 8'h3b, 1'b0);
         6'd23: w = cw(SRC_LIT, 8'h34, 1'b0);
         6'd24: w = cw(SRC_LIT, 8'h30, 1'b0);
         6'd25: w = cw(SRC_LIT, 8'h6d, 1'b1);
         6'd26: w = cw(SRC_LIT, CSI_BYTE, 1'b0);
         6'd27: w = cw(SRC_ROW_T, 8'h00, 1'b0);
         6'd28: w = cw(SRC_ROW_O, 8'h00, 1'b0);
         6'd29: w = cw(SRC_LIT, 8'h3b, 1'b0);
         6'd30: w = cw(SRC_COL_T, 8'h00, 1'b0);
         6'd31: w = cw(SRC_COL_O, 8'h00, 1'b0);
         6'd32: w = cw(SRC_LIT, 8'h48, 1'b1);
         default: w = cw(SRC_LIT, 8'h00, 1'b1);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: sv/vtc_req_if.sv
`default_nettype none
interface vtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface
`default_nettype wire

FILE: sv/vtc_rsp_if.sv
`default_nettype none
interface vtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/vtc_sequencer.sv
`default_nettype none
module vtc_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vtc_pkg::seq_start_type start,
   input  wire logic [7:0]            cursor_row,
   input  wire logic [7:0]            cursor_col,
   output logic                       busy,
   vtc_rsp_if.source                  rsp_if
);
   import vtc_pkg::*;

   logic               busy_ff, busy_in;
   logic [PcWidth-1:0] pc_ff, pc_in;
   logic [7:0]         arg_ff, arg_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;

   ctrl_word_type word;
   logic          advance;
   logic [7:0]    coord;
   logic [14:0]   prod;
   logic [3:0]    quot;
   logic [6:0]    tens_part;
   logic [6:0]    rem;
   logic          above_nine;
   logic [7:0]    tens_digit;
   logic [7:0]    ones_digit;
   logic [7:0]    step_byte;

   assign word    = microcode(pc_ff);
   assign advance = busy_ff && (!out_valid_ff || rsp_if.ready);

   // Two decimal digits of a coordinate; the quotient by ten uses 205/2048.
   always_comb begin
      if (word.src == SRC_ROW_T || word.src == SRC_ROW_O) begin
         coord = cursor_row;
      end else begin
         coord = cursor_col;
      end
      prod       = {8'b0, coord[6:0]} * 15'd205;
      quot       = prod[14:11];
      tens_part  = {3'b0, quot} * 7'd10;
      rem        = coord[6:0] - tens_part;
      above_nine = !coord[7] && (coord[6:0] > 7'd9);
      if (above_nine) begin
         tens_digit = DIGIT_ZERO + {4'b0, quot};
         ones_digit = DIGIT_ZERO + {4'b0, rem[3:0]};
      end else begin
         tens_digit = DIGIT_ZERO;
         ones_digit = coord + DIGIT_ZERO;
      end
   end

   always_comb begin
      case (word.src)
         SRC_LIT:   step_byte = word.lit;
         SRC_ARG:   step_byte = arg_ff;
         SRC_ROW_T: step_byte = tens_digit;
         SRC_ROW_O: step_byte = ones_digit;
         SRC_COL_T: step_byte = tens_digit;
         SRC_COL_O: step_byte = ones_digit;
         default:   step_byte = word.lit;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      arg_in       = arg_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (start.go && !busy_ff) begin
         busy_in = 1'b1;
         pc_in   = start.pc;
         arg_in  = start.arg;
      end else if (advance) begin
         pc_in = pc_ff + 1'b1;
         if (word.last) begin
            busy_in = 1'b0;
         end
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = step_byte;
         out_last_in  = word.last;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      pc_ff       <= pc_in;
      arg_ff      <= arg_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign busy            = busy_ff;
   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.last     = out_last_ff;

endmodule
`default_nettype wire

FILE: sv/vt52_to_csi_translator.sv
`default_nettype none
// Channel   Direction  Payload             Transaction
// req_if    in         char_in[7:0]        one terminal byte from the host
// rsp_if    out        out_byte[7:0], last one console byte; last ends a sequence
//
// A byte that emits nothing is only decoded; a byte that emits n bytes is first
// dispatched into the microcode table, which then emits them one per step.
// The microcode step counter emits one byte per cycle while the output register
// is free. Synchronous reset returns to normal phase with zeroed positions.
// A stalled output holds the sequencer; a new byte is taken once it finishes.
module vt52_to_csi_translator (
   input  wire logic clock,
   input  wire logic reset,
   vtc_req_if.sink   req_if,
   vtc_rsp_if.source rsp_if
);
   import vtc_pkg::*;

   localparam logic [7:0] CH_CTRL_D = 8'h04;
   localparam logic [7:0] CH_CTRL_E = 8'h05;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_CTRL_S = 8'h13;
   localparam logic [7:0] CH_CTRL_X = 8'h18;
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_B   = 8'h42;
   localparam logic [7:0] CH_UP_C   = 8'h43;
   localparam logic [7:0] CH_UP_D   = 8'h44;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_UP_H   = 8'h48;
   localparam logic [7:0] CH_UP_I   = 8'h49;
   localparam logic [7:0] CH_UP_J   = 8'h4a;
   localparam logic [7:0] CH_UP_K   = 8'h4b;
   localparam logic [7:0] CH_UP_L   = 8'h4c;
   localparam logic [7:0] CH_UP_M   = 8'h4d;
   localparam logic [7:0] CH_UP_Y   = 8'h59;
   localparam logic [7:0] CH_LO_D   = 8'h64;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_J   = 8'h6a;
   localparam logic [7:0] CH_LO_K   = 8'h6b;
   localparam logic [7:0] CH_LO_L   = 8'h6c;
   localparam logic [7:0] CH_LO_O   = 8'h6f;
   localparam logic [7:0] CH_LO_P   = 8'h70;
   localparam logic [7:0] CH_LO_Q   = 8'h71;
   localparam logic [7:0] CH_LO_V   = 8'h76;
   localparam logic [7:0] CH_LO_W   = 8'h77;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_ESC,
      PH_ROW,
      PH_COL
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [7:0]    cursor_row_ff, cursor_row_in;
   logic [7:0]    cursor_col_ff, cursor_col_in;
   logic [7:0]    saved_row_ff, saved_row_in;
   logic [7:0]    saved_col_ff, saved_col_in;
   seq_start_type start;
   logic          seq_busy;
   logic          accept;
   logic [7:0]    c;

   assign req_if.ready = !seq_busy;
   assign accept       = req_if.valid && !seq_busy;
   assign c            = req_if.char_in;

   always_comb begin
      phase_in      = phase_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      saved_row_in  = saved_row_ff;
      saved_col_in  = saved_col_ff;
      start.go      = 1'b0;
      start.pc      = A_ARG;
      start.arg     = c;
      case (phase_ff)
         PH_NORMAL: begin
            case (c)
               CH_ESC: phase_in = PH_ESC;
               CH_BS, CH_TAB, CH_LF, CH_CR: start.go = 1'b1;
               CH_CTRL_D: begin
                  start.go  = 1'b1;
                  start.pc  = A_CSI_ARG;
                  start.arg = CH_UP_C;
               end
               CH_CTRL_E: begin
                  start.go  = 1'b1;
                  start.pc  = A_CSI_ARG;
                  start.arg = CH_UP_A;
               end
               CH_CTRL_S: begin
                  start.go  = 1'b1;
                  start.pc  = A_CSI_ARG;
                  start.arg = CH_UP_D;
               end
               CH_CTRL_X: begin
                  start.go  = 1'b1;
                  start.pc  = A_CSI_ARG;
                  start.arg = CH_UP_B;
               end
               default: start.go = (c >= CH_SPACE);
            endcase
         end
         PH_ESC: begin
            phase_in = PH_NORMAL;
            start.go = 1'b1;
            case (c)
               CH_UP_A, CH_UP_B, CH_UP_C, CH_UP_D, CH_UP_H, CH_UP_J, CH_UP_K, CH_UP_M:
                  start.pc = A_CSI_ARG;
               CH_UP_E: start.arg = CH_FF;
               CH_UP_I: begin
                  start.pc  = A_CSI_ARG;
                  start.arg = CH_UP_L;
               end
               CH_UP_L: start.pc = A_LINE;
               CH_UP_Y: begin
                  phase_in = PH_ROW;
                  start.go = 1'b0;
               end
               CH_LO_E: start.pc = A_CUR_ON;
               CH_LO_F: start.pc = A_CUR_OFF;
               CH_LO_J: begin
                  saved_row_in = cursor_row_ff;
                  saved_col_in = cursor_col_ff;
                  start.go     = 1'b0;
               end
               CH_LO_K: begin
                  cursor_row_in = saved_row_ff;
                  cursor_col_in = saved_col_ff;
                  start.pc      = A_CURSOR;
               end
               CH_LO_L: start.pc = A_DEL_INS;
               CH_LO_P: begin
                  start.pc  = A_VIDEO;
                  start.arg = CH_SEVEN;
               end
               CH_LO_Q: begin
                  start.pc  = A_VIDEO;
                  start.arg = CH_ZERO;
               end
               CH_LO_D, CH_LO_O, CH_LO_V, CH_LO_W: start.go = 1'b0;
               default: start.pc = A_ARG;
            endcase
         end
         PH_ROW: begin
            cursor_row_in = c - POS_BIAS;
            phase_in      = PH_COL;
         end
         PH_COL: begin
            cursor_col_in = c - POS_BIAS;
            phase_in      = PH_NORMAL;
            start.go      = 1'b1;
            start.pc      = A_CURSOR;
         end
         default: phase_in = PH_NORMAL;
      endcase
      if (!accept) begin
         phase_in      = phase_ff;
         cursor_row_in = cursor_row_ff;
         cursor_col_in = cursor_col_ff;
         saved_row_in  = saved_row_ff;
         saved_col_in  = saved_col_ff;
         start.go      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NORMAL;
         cursor_row_ff <= 8'd0;
         cursor_col_ff <= 8'd0;
         saved_row_ff  <= 8'd0;
         saved_col_ff  <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         saved_row_ff  <= saved_row_in;
         saved_col_ff  <= saved_col_in;
      end
   end

   vtc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cursor_row (cursor_row_ff),
      .cursor_col (cursor_col_ff),
      .busy       (seq_busy),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import vtc_pkg::*;

   localparam logic [7:0] ESC_CHAR = 8'd27;
   localparam logic [7:0] CTRL_BS  = 8'd8;
   localparam logic [7:0] CTRL_TAB = 8'd9;
   localparam logic [7:0] CTRL_LF  = 8'd10;
   localparam logic [7:0] CTRL_CR  = 8'd13;
   localparam logic [7:0] CTRL_D   = 8'd4;
   localparam logic [7:0] CTRL_E   = 8'd5;
   localparam logic [7:0] CTRL_S   = 8'd19;
   localparam logic [7:0] CTRL_X   = 8'd24;
   localparam logic [7:0] CTRL_BEL = 8'd7;
   localparam logic [7:0] FORM_FEED = 8'h0c;
   localparam logic [7:0] SEMICOLON = 8'h3b;
   localparam logic [7:0] CUP_FINAL = 8'h48;
   localparam int         STREAM_ITEMS = 410;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_ROW,
      PH_COL
   } esc_phase_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } console_beat_type;

   logic clock;
   logic reset;

   vtc_req_if req_if ();
   vtc_rsp_if rsp_if ();

   vt52_to_csi_translator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   console_beat_type console_bytes_q[$];
   logic [7:0]       pending_q[$];
   esc_phase_type    phase;
   logic [7:0]       row;
   logic [7:0]       col;
   logic [7:0]       saved_row;
   logic [7:0]       saved_col;
   int               mismatches;
   bit               tx_idle;
   bit               rx_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void stage_csi(logic [7:0] b);
      pending_q.push_back(CSI_BYTE);
      pending_q.push_back(b);
   endfunction

   function automatic void stage_coord(logic [7:0] v);
      int s;
      s = $signed(v);
      if (s > 9) begin
         pending_q.push_back(8'(48 + s / 10));
         pending_q.push_back(8'(48 + s % 10));
      end else begin
         pending_q.push_back(DIGIT_ZERO);
         pending_q.push_back(8'(s + 48));
      end
   endfunction

   function automatic void stage_cursor();
      pending_q.push_back(CSI_BYTE);
      stage_coord(row);
      pending_q.push_back(SEMICOLON);
      stage_coord(col);
      pending_q.push_back(CUP_FINAL);
   endfunction

   function automatic void stage_text(string s);
      pending_q.push_back(CSI_BYTE);
      for (int i = 0; i < s.len(); i++) pending_q.push_back(s[i]);
   endfunction

   function automatic void predict_translation(logic [7:0] c);
      pending_q.delete();
      case (phase)
         PH_TEXT: begin
            case (c)
               ESC_CHAR: phase = PH_ESC;
               CTRL_BS, CTRL_TAB, CTRL_LF, CTRL_CR: pending_q.push_back(c);
               CTRL_D: stage_csi(8'h43);
               CTRL_E: stage_csi(8'h41);
               CTRL_S: stage_csi(8'h44);
               CTRL_X: stage_csi(8'h42);
               default: if (c >= 8'd32) pending_q.push_back(c);
            endcase
         end
         PH_ESC: begin
            phase = PH_TEXT;
            case (c)
               "A": stage_csi(8'h41);
               "B": stage_csi(8'h42);
               "C": stage_csi(8'h43);
               "D": stage_csi(8'h44);
               "E": pending_q.push_back(FORM_FEED);
               "I": stage_csi(8'h4c);
               "H": stage_csi(8'h48);
               "J": stage_csi(8'h4a);
               "K": stage_csi(8'h4b);
               "L": begin
                  pending_q.push_back(CTRL_LF);
                  stage_csi(8'h4c);
               end
               "M": stage_csi(8'h4d);
               "Y": phase = PH_ROW;
               "e": begin
                  stage_csi(8'h20);
                  pending_q.push_back(8'h70);
               end
               "f": begin
                  stage_csi(8'h30);
                  pending_q.push_back(8'h20);
                  pending_q.push_back(8'h70);
               end
               "j": begin
                  saved_row = row;
                  saved_col = col;
               end
               "k": begin
                  row = saved_row;
                  col = saved_col;
                  stage_cursor();
               end
               "l": begin
                  stage_csi(8'h4d);
                  stage_csi(8'h4c);
               end
               "p": stage_text("7;31;40m");
               "q": stage_text("0;31;40m");
               "d", "o", "v", "w": ;
               default: pending_q.push_back(c);
            endcase
         end
         PH_ROW: begin
            row = c - POS_BIAS;
            phase = PH_COL;
         end
         default: begin
            col = c - POS_BIAS;
            phase = PH_TEXT;
            stage_cursor();
         end
      endcase
      foreach (pending_q[i])
         console_bytes_q.push_back(console_beat_type'{code: pending_q[i],
                                                      last: (i == pending_q.size() - 1)});
   endfunction

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = tx_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.char_in <= c;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_translation(c);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (console_bytes_q.size() != 0);
   endtask

   // Each rsp transaction is compared with the oldest predicted console byte.
   always @(posedge clock) begin
      console_beat_type exp_beat;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (console_bytes_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_if.out_byte, rsp_if.last));
         end else begin
            exp_beat = console_bytes_q.pop_front();
            if (rsp_if.out_byte !== exp_beat.code)
               report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                         rsp_if.out_byte, exp_beat.code));
            if (rsp_if.last !== exp_beat.last)
               report_mismatch($sformatf("last %0b, predicted %0b on byte %02h",
                                         rsp_if.last, exp_beat.last, exp_beat.code));
         end
      end
   end

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = rx_idle ? $urandom_range(0, 13) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1 || reset);
         @(negedge clock);
      end
   end

   task automatic test_control_codes();
      send_char(8'h00);
      send_char(CTRL_D);
      send_char(CTRL_E);
      send_char(CTRL_BEL);
      send_char(CTRL_S);
      send_char(CTRL_X);
      send_char(8'h1f);
      send_char(8'h7f);
      send_char(8'hff);
   endtask

   task automatic test_cursor_set();
      send_char(ESC_CHAR);
      send_char("Y");
      send_char(8'h00);
      send_char(8'hff);
      send_char(ESC_CHAR);
      send_char("Y");
      send_char(8'd158);
      send_char(8'd40);
   endtask

   task automatic test_save_restore();
      send_char(ESC_CHAR);
      send_char("j");
      send_char(ESC_CHAR);
      send_char("k");
   endtask

   task automatic test_video_and_unknown();
      send_char(ESC_CHAR);
      send_char("p");
      send_char(ESC_CHAR);
      send_char(ESC_CHAR);
   endtask

   task automatic test_random_stream();
      string      esc_finals;
      int         sent;
      int         pick;
      bit         paused;
      logic [7:0] c;
      esc_finals = "ABCDEIHJKLMYefjklpqdovw";
      sent = 0;
      paused = 1'b0;
      while (sent < STREAM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
         end
         if (!paused && sent >= STREAM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_char(ESC_CHAR);
            if ($urandom_range(0, 5) == 0)
               c = 8'($urandom_range(0, 255));
            else
               c = esc_finals[$urandom_range(0, esc_finals.len() - 1)];
            send_char(c);
            sent += 2;
            if (c == "Y") begin
               send_char(8'($urandom_range(0, 255)));
               send_char(8'($urandom_range(0, 255)));
               sent += 2;
            end
         end else if (pick < 85) begin
            send_char(8'($urandom_range(0, 31)));
            sent++;
         end else begin
            send_char(8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.char_in = 8'h00;
      mismatches = 0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      phase = PH_TEXT;
      row = 8'h00;
      col = 8'h00;
      saved_row = 8'h00;
      saved_col = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_control_codes();
      test_cursor_set();
      test_save_restore();
      test_video_and_unknown();
      test_random_stream();
      wait_drained();
      repeat (20) @(posedge clock);
      if (console_bytes_q.size() != 0)
         report_mismatch($sformatf("%0d predicted bytes never arrived",
                                   console_bytes_q.size()));
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/vtc_pkg.sv
sv/vtc_req_if.sv
sv/vtc_rsp_if.sv
sv/vtc_sequencer.sv
sv/vt52_to_csi_translator.sv
tb/tb_top.sv
